### design/fcv_pkg.sv
// Shared types, codes and helpers for the FAT12 cluster chain verifier.
package fcv_pkg;

  localparam int unsigned FAT_ENTRIES_DEF = 4096;
  localparam int unsigned BLOCK_BYTES_DEF = 512;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_VERIFY = 1'b1;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SHORT  = 3'd1;
  localparam logic [2:0] ST_NO_END = 3'd2;
  localparam logic [2:0] ST_RANGE  = 3'd3;
  localparam logic [2:0] ST_LENGTH = 3'd4;

  localparam logic [11:0] END_LOW  = 12'hff8;
  localparam logic [11:0] END_HIGH = 12'hfff;

  typedef struct packed {
    logic        action;
    logic [12:0] byte_address;
    logic [7:0]  byte_value;
    logic [11:0] start_cluster;
    logic [31:0] file_length;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [12:0] blocks_walked;
  } out_t;

  function automatic logic is_end(input logic [11:0] v);
    return (v >= END_LOW) && (v <= END_HIGH);
  endfunction

endpackage

### design/fcv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fcv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 6144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### design/fcv_unpack.sv
// FAT12 entry addressing and unpacking of two stored bytes into a 12-bit entry.
module fcv_unpack #(
  parameter int unsigned AW = 13
) (
  input  logic [11:0]   idx_i,
  input  logic [7:0]    lo_i,
  input  logic [7:0]    hi_i,
  input  logic          hi_zero_i,
  output logic [AW-1:0] pos_o,
  output logic [11:0]   entry_o
);

  logic [12:0] pos_full;
  logic [15:0] word;

  assign pos_full = {1'b0, idx_i} + {2'b00, idx_i[11:1]};
  assign pos_o    = AW'(pos_full);
  assign word     = {(hi_zero_i ? 8'h00 : hi_i), lo_i};
  assign entry_o  = idx_i[0] ? word[15:4] : word[11:0];

endmodule

### design/fat12_cluster_chain_verifier_core.sv
// Top level of the FAT12 cluster chain verifier: sequencer, FAT store and config register.
//
// Usage:
//   Items are offered on in_i with start; a transfer happens when start is high and busy
//   is low. A load (action 0) writes one byte of the packed FAT at the transfer edge and
//   gives no result; busy stays low, so loads can follow every cycle.
//   A verify (action 1) walks the chain one FAT entry at a time. Each entry passes the
//   states check, low byte and high byte on the single read port of the FAT store, so a
//   verify of a file of N blocks (an empty file counts as one) that reaches the final
//   check reads N entries before res_strobe_o rises; early verdicts come sooner, and the
//   result for a length that is too large is shown in the cycle after the transfer.
//   The result is shown on res_o for one cycle with res_strobe_o high, and busy is low
//   again in that cycle. The receiver cannot stall; the result is taken at that edge.
//   cfg_data_i sets the number of FAT entries in use; write it only while idle.
//   Reset returns the sequencer to idle and the limit to FAT_ENTRIES; the FAT store
//   is not cleared and must be loaded before use.
module fat12_cluster_chain_verifier_core #(
  parameter int unsigned FAT_ENTRIES = fcv_pkg::FAT_ENTRIES_DEF,
  parameter int unsigned BLOCK_BYTES = fcv_pkg::BLOCK_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  fcv_pkg::in_t in_i,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [12:0]  cfg_data_i,
  output logic         res_strobe_o,
  output fcv_pkg::out_t res_o
);

  localparam int unsigned STORE_BYTES = (FAT_ENTRIES * 3) / 2;
  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam int unsigned SH = $clog2(BLOCK_BYTES);
  localparam int unsigned BW = 33 - SH;
  localparam int unsigned CW = $clog2(FAT_ENTRIES + 1);
  localparam logic [12:0] STORE_L = 13'(STORE_BYTES);
  localparam logic [12:0] FAT_L   = 13'(FAT_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_LO,
    S_HI
  } state_e;

  state_e        state_q, state_d;
  logic [11:0]   cur_q, cur_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] walked_q, walked_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [7:0]    lo_q, lo_d;
  logic          hi_zero_q, hi_zero_d;
  logic [12:0]   cfg_q, cfg_d;
  logic          strobe_q, strobe_d;
  fcv_pkg::out_t res_q, res_d;

  logic          accept;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic [AW-1:0] pos_w;
  logic [11:0]   entry_w;
  logic [12:0]   pos_next;
  logic [12:0]   limit;
  logic [BW-1:0] blocks;
  logic          too_big;

  assign busy         = (state_q != S_IDLE);
  assign accept       = start && !busy;
  assign cfg_ready_o  = 1'b1;
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

  assign ram_we   = accept && (in_i.action == fcv_pkg::ACT_LOAD) && (in_i.byte_address < STORE_L);
  assign pos_next = 13'(pos_q) + 13'd1;
  assign limit    = (cfg_q > FAT_L) ? FAT_L : cfg_q;

  assign blocks  = {1'b0, in_i.file_length[31:SH]} + BW'(|in_i.file_length[SH-1:0]);
  assign too_big = blocks > BW'(FAT_ENTRIES);

  fcv_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(in_i.byte_address)),
    .wdata_i (in_i.byte_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fcv_unpack #(
    .AW (AW)
  ) u_unpack (
    .idx_i     (cur_q),
    .lo_i      (lo_q),
    .hi_i      (ram_rdata),
    .hi_zero_i (hi_zero_q),
    .pos_o     (pos_w),
    .entry_o   (entry_w)
  );

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    rem_d     = rem_q;
    walked_d  = walked_q;
    pos_d     = pos_q;
    lo_d      = lo_q;
    hi_zero_d = hi_zero_q;
    cfg_d     = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : cfg_q;
    strobe_d  = 1'b0;
    res_d     = res_q;
    ram_raddr = (state_q == S_CHECK) ? pos_w : AW'(pos_next);
    case (state_q)
      S_IDLE: begin
        if (accept && (in_i.action == fcv_pkg::ACT_VERIFY)) begin
          if (too_big) begin
            res_d.status        = fcv_pkg::ST_LENGTH;
            res_d.blocks_walked = 13'd0;
            strobe_d            = 1'b1;
          end else begin
            cur_d    = in_i.start_cluster;
            rem_d    = (blocks == '0) ? '0 : CW'(blocks - BW'(1));
            walked_d = '0;
            state_d  = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (fcv_pkg::is_end(cur_q)) begin
          res_d.status        = fcv_pkg::ST_SHORT;
          res_d.blocks_walked = 13'(walked_q);
          strobe_d            = 1'b1;
          state_d             = S_IDLE;
        end else if ({1'b0, cur_q} >= limit) begin
          res_d.status        = fcv_pkg::ST_RANGE;
          res_d.blocks_walked = 13'(walked_q);
          strobe_d            = 1'b1;
          state_d             = S_IDLE;
        end else begin
          pos_d   = pos_w;
          state_d = S_LO;
        end
      end
      S_LO: begin
        lo_d      = ram_rdata;
        hi_zero_d = pos_next >= STORE_L;
        state_d   = S_HI;
      end
      S_HI: begin
        if (rem_q != '0) begin
          cur_d    = entry_w;
          rem_d    = rem_q - CW'(1);
          walked_d = walked_q + CW'(1);
          state_d  = S_CHECK;
        end else begin
          res_d.status        = fcv_pkg::is_end(entry_w) ? fcv_pkg::ST_OK
                                                         : fcv_pkg::ST_NO_END;
          res_d.blocks_walked = 13'(walked_q);
          strobe_d            = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cfg_q     <= FAT_L;
      strobe_q  <= 1'b0;
      cur_q     <= '0;
      rem_q     <= '0;
      walked_q  <= '0;
      pos_q     <= '0;
      lo_q      <= '0;
      hi_zero_q <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      cfg_q     <= cfg_d;
      strobe_q  <= strobe_d;
      cur_q     <= cur_d;
      rem_q     <= rem_d;
      walked_q  <= walked_d;
      pos_q     <= pos_d;
      lo_q      <= lo_d;
      hi_zero_q <= hi_zero_d;
      res_q     <= res_d;
    end
  end

`ifndef SYNTH
  a_end_of_walk_strobes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_strobe_o)
    else $error("walk ended without a result");

  a_length_no_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && (res_o.status == fcv_pkg::ST_LENGTH)) |-> (res_o.blocks_walked == 13'd0))
    else $error("length verdict with links walked");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> (res_o.status <= fcv_pkg::ST_LENGTH))
    else $error("status code out of range");

  a_strobe_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |=> !res_strobe_o || $past(accept))
    else $error("result strobe repeated without a new transfer");
`endif

endmodule
